@@ hw/rtl/dett_pkg.sv @@
// ----------------------------------------------------------------------------
// dett_pkg
// Shared types and constants for the delayed event timer table.
// ----------------------------------------------------------------------------
package dett_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned DelayW = 24;
  localparam int unsigned ElaW   = 32;
  localparam int unsigned LimitW = 9;
  localparam int unsigned ReqW   = 3;

  // request type codes on the input channel
  localparam logic [ReqW-1:0] REQ_TICK    = 3'd0;
  localparam logic [ReqW-1:0] REQ_PUSH    = 3'd1;
  localparam logic [ReqW-1:0] REQ_CANCEL  = 3'd2;
  localparam logic [ReqW-1:0] REQ_POP     = 3'd3;
  localparam logic [ReqW-1:0] REQ_QUERY   = 3'd4;
  localparam logic [ReqW-1:0] REQ_QCANCEL = 3'd5;

  // configuration register indexes
  localparam logic CFG_EVENT_LIMIT = 1'b0;
  localparam logic CFG_CLEAR_ALL   = 1'b1;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_FAIL    = 3'd0,
    OP_TICK    = 3'd1,
    OP_PUSH    = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_POP     = 3'd4,
    OP_QUERY   = 3'd5,
    OP_QCANCEL = 3'd6
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              clr_all;
    logic [CodeW-1:0]  code;
    logic [DelayW-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [DelayW-1:0] rem;
    logic [ElaW-1:0]   ela;
  } entry_t;

endpackage

@@ hw/rtl/dett_front.sv @@
// ----------------------------------------------------------------------------
// dett_front
// Accepts requests, checks codes against the configuration and queues
// classified commands for the back end.
// ----------------------------------------------------------------------------
module dett_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [dett_pkg::LimitW-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dett_pkg::ReqW-1:0]      in_req_type,
  input  logic [dett_pkg::CodeW-1:0]     in_event_code,
  input  logic [dett_pkg::DelayW-1:0]    in_delay_ticks,
  output logic                           cmd_valid,
  input  logic                           cmd_pop,
  output dett_pkg::cmd_t                 cmd
);

  logic [dett_pkg::LimitW-1:0] limit_r;
  logic [dett_pkg::CodeW-1:0]  clr_code_r;
  dett_pkg::cmd_t              cls;
  logic                        code_ok;
  dett_pkg::cmd_t              q_r [2];
  logic                        wp_r, rp_r;
  logic [1:0]                  cnt_r;
  logic                        push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= dett_pkg::LimitW'(16);
      clr_code_r <= dett_pkg::CodeW'(1);
    end else if (cfg_we) begin
      if (cfg_index == dett_pkg::CFG_EVENT_LIMIT) limit_r <= cfg_wdata;
      else clr_code_r <= cfg_wdata[dett_pkg::CodeW-1:0];
    end
  end

  // classify the request
  assign code_ok = (in_event_code != '0) && ({1'b0, in_event_code} < limit_r);
  always_comb begin
    cls.code    = in_event_code;
    cls.delay   = in_delay_ticks;
    cls.clr_all = (in_event_code == clr_code_r);
    unique case (in_req_type)
      dett_pkg::REQ_TICK:    cls.op = dett_pkg::OP_TICK;
      dett_pkg::REQ_POP:     cls.op = dett_pkg::OP_POP;
      dett_pkg::REQ_PUSH:    cls.op = code_ok ? dett_pkg::OP_PUSH : dett_pkg::OP_FAIL;
      dett_pkg::REQ_CANCEL:  cls.op = code_ok ? dett_pkg::OP_CANCEL : dett_pkg::OP_FAIL;
      dett_pkg::REQ_QUERY:   cls.op = code_ok ? dett_pkg::OP_QUERY : dett_pkg::OP_FAIL;
      dett_pkg::REQ_QCANCEL: cls.op = code_ok ? dett_pkg::OP_QCANCEL : dett_pkg::OP_FAIL;
      default:               cls.op = dett_pkg::OP_FAIL;
    endcase
  end

  // two-entry command queue
  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      case ({push, cmd_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/dett_back.sv @@
// ----------------------------------------------------------------------------
// dett_back
// Sequencer over the entry memory: search, tick walk and shift-down removal,
// with a result register towards the output channel.
// ----------------------------------------------------------------------------
module dett_back #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  input  dett_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [dett_pkg::CodeW-1:0]     out_expired_event,
  output logic [dett_pkg::DelayW-1:0]    out_remaining_ticks,
  output logic [dett_pkg::ElaW-1:0]      out_elapsed_ticks
);

  localparam int unsigned IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] MaxUsed = IW'(SLOTS - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRCH = 9'b000000010,
    S_SCHK = 9'b000000100,
    S_ACT  = 9'b000001000,
    S_TRD  = 9'b000010000,
    S_TCHK = 9'b000100000,
    S_SHRD = 9'b001000000,
    S_SHWR = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  dett_pkg::entry_t mem [SLOTS];
  dett_pkg::entry_t rd_data_r, wr_data;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic             wr_en;

  state_t                      state_r, state_nxt;
  dett_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [IW-1:0]               idx_r, idx_nxt, used_r, used_nxt, idx_inc;
  logic                        found_r, found_nxt;
  logic                        ok_r, ok_nxt;
  logic [dett_pkg::CodeW-1:0]  exp_r, exp_nxt;
  logic [dett_pkg::DelayW-1:0] rem_r, rem_nxt;
  logic [dett_pkg::ElaW-1:0]   ela_r, ela_nxt;
  logic                        out_load;
  logic                        out_valid_r;
  logic                        o_ok_r;
  logic [dett_pkg::CodeW-1:0]  o_exp_r;
  logic [dett_pkg::DelayW-1:0] o_rem_r;
  logic [dett_pkg::ElaW-1:0]   o_ela_r;

  assign idx_inc = idx_r + 1'b1;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign rd_addr = (state_r == S_SHRD) ? idx_inc : idx_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    found_nxt = found_r;
    ok_nxt    = ok_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    ela_nxt   = ela_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data_r;
    cmd_pop   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
          exp_nxt   = '0;
          rem_nxt   = '0;
          ela_nxt   = '0;
          unique case (cmd.op)
            dett_pkg::OP_FAIL: state_nxt = S_OUT;
            dett_pkg::OP_TICK: state_nxt = S_TRD;
            dett_pkg::OP_POP: begin
              ok_nxt    = (used_r != '0);
              state_nxt = (used_r != '0) ? S_SHRD : S_OUT;
            end
            default: state_nxt = S_SRCH;
          endcase
        end
      end
      S_SRCH: state_nxt = (idx_r == used_r) ? S_ACT : S_SCHK;
      S_SCHK: begin
        if (rd_data_r.code == cmd_r.code) begin
          found_nxt = 1'b1;
          rem_nxt   = rd_data_r.rem;
          ela_nxt   = rd_data_r.ela;
          state_nxt = S_ACT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH;
        end
      end
      S_ACT: begin
        state_nxt = S_OUT;
        unique case (cmd_r.op)
          dett_pkg::OP_PUSH: begin
            rem_nxt = '0;
            ela_nxt = '0;
            wr_data = '{code: cmd_r.code, rem: cmd_r.delay, ela: '0};
            if (found_r) begin
              wr_en  = 1'b1;
              ok_nxt = 1'b1;
            end else if (used_r < MaxUsed) begin
              wr_en    = 1'b1;
              wr_addr  = used_r;
              used_nxt = used_r + 1'b1;
              ok_nxt   = 1'b1;
            end
          end
          dett_pkg::OP_QUERY: ok_nxt = found_r;
          default: begin
            // cancel, or query then cancel
            if (cmd_r.op == dett_pkg::OP_QCANCEL) begin
              ok_nxt = found_r;
            end else begin
              ok_nxt  = found_r || cmd_r.clr_all;
              rem_nxt = '0;
              ela_nxt = '0;
            end
            if (cmd_r.clr_all) used_nxt = '0;
            else if (found_r) state_nxt = S_SHRD;
          end
        endcase
      end
      S_TRD: state_nxt = (idx_r == used_r) ? S_OUT : S_TCHK;
      S_TCHK: begin
        if (rd_data_r.rem == dett_pkg::DelayW'(1)) begin
          ok_nxt    = 1'b1;
          exp_nxt   = rd_data_r.code;
          state_nxt = S_SHRD;
        end else begin
          wr_en   = 1'b1;
          wr_data.rem = (rd_data_r.rem != '0) ? rd_data_r.rem - 1'b1 : rd_data_r.rem;
          wr_data.ela = (rd_data_r.ela != '1) ? rd_data_r.ela + 1'b1 : rd_data_r.ela;
          idx_nxt   = idx_inc;
          state_nxt = S_TRD;
        end
      end
      S_SHRD: begin
        if (idx_inc == used_r) begin
          used_nxt  = used_r - 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SHRD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    ok_r    <= ok_nxt;
    exp_r   <= exp_nxt;
    rem_r   <= rem_nxt;
    ela_r   <= ela_nxt;
    if (out_load) begin
      o_ok_r  <= ok_r;
      o_exp_r <= exp_r;
      o_rem_r <= rem_r;
      o_ela_r <= ela_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = o_ok_r;
  assign out_expired_event   = o_exp_r;
  assign out_remaining_ticks = o_rem_r;
  assign out_elapsed_ticks   = o_ela_r;

endmodule

@@ hw/rtl/delayed_event_timer_table_core.sv @@
// ----------------------------------------------------------------------------
// delayed_event_timer_table_core
// Table of pending timed events with push, tick, cancel, pop and queries.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    req_type, event_code, delay_ticks
//   out_     output     out_valid/out_ready  ok, expired_event, remaining/elapsed
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// a request visits entries in the entry memory (search, tick walk or
// shift-down), each visit a read state and then a check or write state;
// a search followed by a removal visits each entry in use once.
// reset is synchronous, active low; the table needs no clearing pass.
// a two-entry queue takes new transfers while not full, even while the
// sequencer is busy; a result held in the output register stalls the next one.
// ----------------------------------------------------------------------------
module delayed_event_timer_table_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [dett_pkg::LimitW-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dett_pkg::ReqW-1:0]      in_req_type,
  input  logic [dett_pkg::CodeW-1:0]     in_event_code,
  input  logic [dett_pkg::DelayW-1:0]    in_delay_ticks,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [dett_pkg::CodeW-1:0]     out_expired_event,
  output logic [dett_pkg::DelayW-1:0]    out_remaining_ticks,
  output logic [dett_pkg::ElaW-1:0]      out_elapsed_ticks
);

  logic           cmd_valid;
  logic           cmd_pop;
  dett_pkg::cmd_t cmd;

  // request front end
  dett_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_event_code  (in_event_code),
    .in_delay_ticks (in_delay_ticks),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd)
  );

  // table sequencer
  dett_back #(.SLOTS(SLOTS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd_valid),
    .cmd_pop             (cmd_pop),
    .cmd                 (cmd),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ok              (out_ok),
    .out_expired_event   (out_expired_event),
    .out_remaining_ticks (out_remaining_ticks),
    .out_elapsed_ticks   (out_elapsed_ticks)
  );

endmodule
